@@ rtl/core/sliding_window_power_sum_macros.svh @@
// Assertion macros used by the sliding window power sum checker
`ifndef SLIDING_WINDOW_POWER_SUM_MACROS_SVH
`define SLIDING_WINDOW_POWER_SUM_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define SWPS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sliding_window_power_sum check failed");

// next-cycle implication, masked while reset is asserted
`define SWPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sliding_window_power_sum check failed");

// next-cycle implication, checked through reset as well
`define SWPS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sliding_window_power_sum check failed");

`endif

@@ rtl/core/swps_pkg.sv @@
// Package: sizes, constants and types of the sliding window power sum
package swps_pkg;

    localparam int WINDOW     = 32;
    localparam int BLOCK      = 80;

    localparam int SAMPLE_W   = 16;
    localparam int TERM_W     = 32;
    localparam int ENERGY_W   = 32;
    localparam int SLOT_W     = 7;

    localparam int SLOT_MOD   = BLOCK + WINDOW;
    localparam int SLOT_CNT_W = (SLOT_MOD > 1) ? $clog2(SLOT_MOD) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);

    localparam int S_TDATA_W  = 2 * SAMPLE_W;
    localparam int M_TDATA_W  = ((ENERGY_W + SLOT_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [2*SAMPLE_W-1:0] product_t;
    typedef logic [TERM_W-1:0] term_t;
    typedef logic [ENERGY_W-1:0] energy_t;
    typedef logic [SLOT_CNT_W-1:0] slot_cnt_t;
    typedef logic [FILL_W-1:0] fill_t;

endpackage

@@ rtl/core/swps_power.sv @@
// Power term pipeline: input register, product register, term register
module swps_power (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  swps_pkg::sample_t             in_real,
    input  swps_pkg::sample_t             in_imag,
    output logic                          term_valid,
    input  logic                          term_ready,
    output swps_pkg::term_t               term_data
);
    import swps_pkg::*;

    logic     v1_reg, v2_reg, v3_reg;
    logic     adv1, adv2, adv3;
    sample_t  re_reg, im_reg;
    sample_t  nim;
    product_t sq_reg, pr_reg;
    product_t sq_next, pr_next;
    term_t    term_reg, term_next;

    assign adv3     = !v3_reg || term_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // negate imaginary part, wrapping to 16 bits
    assign nim       = -im_reg;
    assign sq_next   = re_reg * re_reg;
    assign pr_next   = im_reg * nim;
    assign term_next = term_t'(sq_reg - pr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            re_reg <= in_real;
            im_reg <= in_imag;
        end
        if (adv2 && v1_reg) begin
            sq_reg <= sq_next;
            pr_reg <= pr_next;
        end
        if (adv3 && v2_reg) begin
            term_reg <= term_next;
        end
    end

    assign term_valid = v3_reg;
    assign term_data  = term_reg;

endmodule

@@ rtl/core/swps_window.sv @@
// Window stage: term shift line, running sum, slot counter, result register
module swps_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          term_valid,
    output logic                          term_ready,
    input  swps_pkg::term_t               term_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output swps_pkg::energy_t             out_energy,
    output logic [swps_pkg::SLOT_W-1:0]   out_slot
);
    import swps_pkg::*;

    term_t     line_reg [WINDOW];
    fill_t     fill_reg;
    energy_t   sum_reg, sum_next;
    slot_cnt_t slot_reg, slot_next;
    logic      vo_reg;
    energy_t   energy_reg;
    slot_cnt_t slot_out_reg;
    term_t     oldest;
    logic      full;
    logic      take;

    assign term_ready = !vo_reg || out_ready;
    assign take       = term_valid && term_ready;

    // slots not yet filled since reset read as zero
    assign full      = (fill_reg == fill_t'(WINDOW));
    assign oldest    = full ? line_reg[WINDOW-1] : '0;
    assign sum_next  = sum_reg + term_data - oldest;
    assign slot_next = (slot_reg == slot_cnt_t'(SLOT_MOD - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            sum_reg  <= '0;
            slot_reg <= '0;
            vo_reg   <= 1'b0;
        end else begin
            if (term_ready) begin
                vo_reg <= term_valid;
            end
            if (take) begin
                sum_reg  <= sum_next;
                slot_reg <= slot_next;
                if (!full) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            line_reg[0]  <= term_data;
            for (int i = 1; i < WINDOW; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
            energy_reg   <= sum_next;
            slot_out_reg <= slot_reg;
        end
    end

    assign out_valid  = vo_reg;
    assign out_energy = energy_reg;
    assign out_slot   = SLOT_W'(slot_out_reg);

endmodule

@@ rtl/core/sliding_window_power_sum.sv @@
// Pipeline: four register stages (input, product, term, result) from s_tdata to m_tdata.
// Throughput: one sample beat per cycle; three term stages and the result register each stall
// only when the stage after them is full and not advancing.
// Reset (aresetn low, synchronous) empties every stage, zeroes the window sum and slot counter;
// the term shift line reads as zero until WINDOW samples have entered it.
module sliding_window_power_sum (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] sample_real, [31:16] sample_imag
    input  logic [swps_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] window_energy, [38:32] slot_index, [39] zero
    output logic [swps_pkg::M_TDATA_W-1:0]     m_tdata
);
    import swps_pkg::*;

    logic              term_valid;
    logic              term_ready;
    term_t             term_data;
    energy_t           energy;
    logic [SLOT_W-1:0] slot;

    swps_power u_power (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_real    (sample_t'(s_tdata[SAMPLE_W-1:0])),
        .in_imag    (sample_t'(s_tdata[2*SAMPLE_W-1:SAMPLE_W])),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term_data  (term_data)
    );

    swps_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term_data  (term_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_energy (energy),
        .out_slot   (slot)
    );

    assign m_tdata = M_TDATA_W'({slot, energy});

endmodule

@@ rtl/core/swps_checker.sv @@
// Port checker for the sliding window power sum, bound to the top level
`include "sliding_window_power_sum_macros.svh"

module swps_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [swps_pkg::M_TDATA_W-1:0]     m_tdata
);
    import swps_pkg::*;

    logic              seen_reg;
    logic [SLOT_W-1:0] last_slot_reg;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] expect_slot;
    logic              m_beat;
    logic              s_beat;
    logic              m_stall;
    logic              quiet_start;

    assign slot        = m_tdata[ENERGY_W+SLOT_W-1:ENERGY_W];
    assign m_beat      = m_tvalid && m_tready;
    assign s_beat      = s_tvalid && s_tready;
    assign m_stall     = m_tvalid && !m_tready;
    assign quiet_start = !s_beat && !m_tvalid && !seen_reg;
    assign expect_slot = (last_slot_reg == SLOT_W'(SLOT_MOD - 1)) ? '0
                                                                  : last_slot_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_beat) begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_beat) begin
            last_slot_reg <= slot;
        end
    end

    `SWPS_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid)
    `SWPS_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata))
    `SWPS_ASSERT_IMPL(a_slot_step, aclk, aresetn, m_beat && seen_reg, slot == expect_slot)
    `SWPS_ASSERT_IMPL(a_first_slot, aclk, aresetn, m_beat && !seen_reg, slot == '0)
    `SWPS_ASSERT_NEXT(a_no_early_result, aclk, aresetn, quiet_start && $past(!aresetn), !m_tvalid)

endmodule

bind sliding_window_power_sum swps_checker u_swps_checker (.*);
